// ===== sv/dsm3_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsm3_pkg
// Types and character codes shared by the decimal entry / median-of-three
// block.
// ----------------------------------------------------------------------------
package dsm3_pkg;

   // parser phases
   typedef enum logic [1:0] {
      PH_SPACE  = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_STOP   = 2'd3
   } phase_type;

   // per-beat control from the top level to the parser and the window
   typedef struct packed {
      logic feed;
      logic push;
      logic wipe;
   } ctl_type;

   localparam logic [7:0] CHAR_TAB     = 8'd9;
   localparam logic [7:0] CHAR_CR      = 8'd13;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_PLUS    = 8'd43;
   localparam logic [7:0] CHAR_MINUS   = 8'd45;
   localparam logic [7:0] CHAR_ZERO    = 8'd48;
   localparam logic [7:0] CHAR_NINE    = 8'd57;
   localparam logic [7:0] CHAR_UPPER_E = 8'd69;
   localparam logic [7:0] CHAR_UPPER_F = 8'd70;
   localparam logic [7:0] CHAR_LOWER_E = 8'd101;
   localparam logic [7:0] CHAR_LOWER_F = 8'd102;

   localparam int unsigned WINDOW_DEPTH = 3;
   localparam logic [1:0]  COUNT_EMPTY  = 2'd0;
   localparam logic [1:0]  COUNT_ONE    = 2'd1;
   localparam logic [1:0]  COUNT_TWO    = 2'd2;
   localparam logic [1:0]  COUNT_FULL   = 2'd3;

   localparam logic KIND_ENTRY   = 1'b0;
   localparam logic KIND_CLEARED = 1'b1;

   localparam int unsigned OUT_VALUE_BITS = 32;
   localparam int unsigned OUT_SUM_BITS   = 34;

endpackage
`default_nettype wire

// ===== sv/dsm3_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsm3_parser
// Incremental decimal parser: skips leading whitespace, takes one sign, then
// digits; saturates the magnitude at 2^(VB-1).
// ----------------------------------------------------------------------------
module dsm3_parser #(
   parameter int unsigned VB = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dsm3_pkg::ctl_type     ctl,
   input  wire logic [7:0]            char_code,
   output logic signed [VB-1:0]       value
);

   localparam logic [VB+3:0] LIMIT_W = {4'b0000, 1'b1, {(VB-1){1'b0}}};
   localparam logic [VB-1:0] MAX_POS = {1'b0, {(VB-1){1'b1}}};
   localparam logic [VB-1:0] MIN_NEG = {1'b1, {(VB-1){1'b0}}};

   dsm3_pkg::phase_type phase_ff, phase_in;
   logic                neg_ff, neg_in;
   logic [VB-1:0]       mag_ff, mag_in;

   logic                is_digit, is_space, is_sign;
   logic [3:0]          digit;
   logic [VB+3:0]       mag_x10;

   assign is_digit = (char_code >= dsm3_pkg::CHAR_ZERO) && (char_code <= dsm3_pkg::CHAR_NINE);
   assign is_space = (char_code == dsm3_pkg::CHAR_SPACE) ||
                     ((char_code >= dsm3_pkg::CHAR_TAB) && (char_code <= dsm3_pkg::CHAR_CR));
   assign is_sign  = (char_code == dsm3_pkg::CHAR_PLUS) || (char_code == dsm3_pkg::CHAR_MINUS);
   assign digit    = 4'(char_code - dsm3_pkg::CHAR_ZERO);
   assign mag_x10  = ((VB+4)'(mag_ff) << 3) + ((VB+4)'(mag_ff) << 1) + (VB+4)'(digit);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (ctl.push) begin
         phase_in = dsm3_pkg::PH_SPACE;
      end else if (ctl.feed) begin
         unique case (phase_ff)
            dsm3_pkg::PH_SPACE: begin
               if (is_digit) begin
                  phase_in = dsm3_pkg::PH_DIGITS;
               end else if (is_sign) begin
                  phase_in = dsm3_pkg::PH_SIGN;
               end else if (!is_space) begin
                  phase_in = dsm3_pkg::PH_STOP;
               end
            end
            dsm3_pkg::PH_SIGN, dsm3_pkg::PH_DIGITS: begin
               phase_in = is_digit ? dsm3_pkg::PH_DIGITS : dsm3_pkg::PH_STOP;
            end
            dsm3_pkg::PH_STOP: begin
               phase_in = dsm3_pkg::PH_STOP;
            end
            default: begin
               phase_in = dsm3_pkg::PH_STOP;
            end
         endcase
      end
   end

   // accumulate
   always_comb begin
      neg_in = neg_ff;
      mag_in = mag_ff;
      if (ctl.push) begin
         neg_in = 1'b0;
         mag_in = '0;
      end else if (ctl.feed && (phase_ff != dsm3_pkg::PH_STOP)) begin
         if (is_digit) begin
            mag_in = (mag_x10 > LIMIT_W) ? LIMIT_W[VB-1:0] : mag_x10[VB-1:0];
         end else if ((phase_ff == dsm3_pkg::PH_SPACE) && is_sign) begin
            neg_in = (char_code == dsm3_pkg::CHAR_MINUS);
         end
      end
   end

   // signed value with clamp
   always_comb begin
      if (neg_ff) begin
         value = mag_ff[VB-1] ? MIN_NEG : -mag_ff;
      end else begin
         value = mag_ff[VB-1] ? MAX_POS : mag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dsm3_pkg::PH_SPACE;
         neg_ff   <= 1'b0;
         mag_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         mag_ff   <= mag_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/dsm3_window.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsm3_window
// Sliding window of the last three entries with sum and median of the window
// as it stands after the current beat.
// ----------------------------------------------------------------------------
module dsm3_window #(
   parameter int unsigned VB = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dsm3_pkg::ctl_type     ctl,
   input  wire logic signed [VB-1:0]  value,
   output logic [1:0]                 count,
   output logic signed [VB+1:0]       sum,
   output logic signed [VB-1:0]       median
);

   logic signed [VB-1:0] win_ff [dsm3_pkg::WINDOW_DEPTH];
   logic signed [VB-1:0] win_in [dsm3_pkg::WINDOW_DEPTH];
   logic [1:0]           cnt_ff, cnt_in;

   logic signed [VB-1:0] a, b, c, lo_ab, hi_ab, lo_hc;
   logic signed [VB:0]   pair_sum;
   logic [VB:0]          pair_adj;

   always_comb begin
      win_in = win_ff;
      cnt_in = cnt_ff;
      if (ctl.wipe) begin
         for (int i = 0; i < dsm3_pkg::WINDOW_DEPTH; i++) begin
            win_in[i] = '0;
         end
         cnt_in = dsm3_pkg::COUNT_EMPTY;
      end else if (ctl.push) begin
         if (cnt_ff == dsm3_pkg::COUNT_FULL) begin
            win_in[0] = win_ff[1];
            win_in[1] = win_ff[2];
            win_in[2] = value;
         end else begin
            for (int i = 0; i < dsm3_pkg::WINDOW_DEPTH; i++) begin
               if (2'(i) == cnt_ff) begin
                  win_in[i] = value;
               end
            end
            cnt_in = cnt_ff + 2'd1;
         end
      end
   end

   // unused slots stay zero, so the full three-way sum serves every count
   assign a        = win_in[0];
   assign b        = win_in[1];
   assign c        = win_in[2];
   assign sum      = (VB+2)'(a) + (VB+2)'(b) + (VB+2)'(c);
   assign pair_sum = (VB+1)'(a) + (VB+1)'(b);
   assign pair_adj = pair_sum + {{VB{1'b0}}, pair_sum[VB]};
   assign lo_ab    = (a < b) ? a : b;
   assign hi_ab    = (a < b) ? b : a;
   assign lo_hc    = (hi_ab < c) ? hi_ab : c;
   assign count    = cnt_in;

   always_comb begin
      unique case (cnt_in)
         dsm3_pkg::COUNT_ONE:   median = a;
         dsm3_pkg::COUNT_TWO:   median = pair_adj[VB:1];
         dsm3_pkg::COUNT_FULL:  median = (lo_ab > lo_hc) ? lo_ab : lo_hc;
         dsm3_pkg::COUNT_EMPTY: median = '0;
         default:               median = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dsm3_pkg::WINDOW_DEPTH; i++) begin
            win_ff[i] <= '0;
         end
         cnt_ff <= dsm3_pkg::COUNT_EMPTY;
      end else begin
         win_ff <= win_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/decimal_entry_sum_median3_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_entry_sum_median3_top
// Character-driven decimal entry with a running sum and median of three.
//
// Request channel (req_): one character per beat. Digits, whitespace and a
// sign build an integer; 'e'/'E' enters it into a window of the last three
// entries and restarts the parser; 'f'/'F' empties the window. Every other
// character stops the number currently being parsed.
// Response channel (rsp_): one beat for each 'e'/'E' (kind 0: value, entries
// held, window sum and median) and one for each 'f'/'F' (kind 1, all zero).
// Other characters produce no beat.
// Throughput: one character per cycle, set by the single input register
// feeding the parser and window logic, while no 'e'/'f' character is held
// there waiting for the output register. A response beat is loaded from the
// input register into the output register once that register is free, and sits in the output register until taken.
// Reset: parser returns to skipping whitespace, the window empties.
// Stall: while a response waits, characters without a response keep flowing;
// a character that needs a response holds in the input register.
// ----------------------------------------------------------------------------
module decimal_entry_sum_median3_top #(
   parameter int unsigned VALUE_BITS = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_char_code,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic              rsp_result_kind,
   output logic signed [31:0] rsp_entered_value,
   output logic [1:0]        rsp_entries_held,
   output logic signed [33:0] rsp_history_sum,
   output logic signed [31:0] rsp_history_median
);

   localparam int unsigned VB = VALUE_BITS;

   logic                 s1_valid_ff, s1_valid_in;
   logic [7:0]           s1_char_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff;
   logic signed [31:0]   rsp_value_ff, rsp_median_ff;
   logic [1:0]           rsp_held_ff;
   logic signed [33:0]   rsp_sum_ff;

   logic                 is_e, is_f, produce, out_free, s1_advance, load_rsp;
   dsm3_pkg::ctl_type    ctl;
   logic signed [VB-1:0] value, median;
   logic signed [VB+1:0] sum;
   logic [1:0]           count;
   logic signed [63:0]   value_w, sum_w, median_w;

   assign is_e = (s1_char_ff == dsm3_pkg::CHAR_LOWER_E) || (s1_char_ff == dsm3_pkg::CHAR_UPPER_E);
   assign is_f = (s1_char_ff == dsm3_pkg::CHAR_LOWER_F) || (s1_char_ff == dsm3_pkg::CHAR_UPPER_F);
   assign produce    = is_e || is_f;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && (!produce || out_free);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign load_rsp   = s1_advance && produce;

   assign ctl.feed = s1_advance && !produce;
   assign ctl.push = s1_advance && is_e;
   assign ctl.wipe = s1_advance && is_f;

   dsm3_parser #(.VB(VB)) u_parser (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .char_code (s1_char_ff),
      .value     (value)
   );

   dsm3_window #(.VB(VB)) u_window (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .value  (value),
      .count  (count),
      .sum    (sum),
      .median (median)
   );

   assign value_w  = 64'(value);
   assign sum_w    = 64'(sum);
   assign median_w = 64'(median);

   assign s1_valid_in  = req_valid ? 1'b1 : (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= req_ready ? s1_valid_in : s1_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_char_ff <= req_char_code;
      end
      if (load_rsp) begin
         rsp_kind_ff <= is_f ? dsm3_pkg::KIND_CLEARED : dsm3_pkg::KIND_ENTRY;
         if (is_f) begin
            rsp_value_ff  <= '0;
            rsp_held_ff   <= dsm3_pkg::COUNT_EMPTY;
            rsp_sum_ff    <= '0;
            rsp_median_ff <= '0;
         end else begin
            rsp_value_ff  <= value_w[dsm3_pkg::OUT_VALUE_BITS-1:0];
            rsp_held_ff   <= count;
            rsp_sum_ff    <= sum_w[dsm3_pkg::OUT_SUM_BITS-1:0];
            rsp_median_ff <= median_w[dsm3_pkg::OUT_VALUE_BITS-1:0];
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_kind_ff;
   assign rsp_entered_value  = rsp_value_ff;
   assign rsp_entries_held   = rsp_held_ff;
   assign rsp_history_sum    = rsp_sum_ff;
   assign rsp_history_median = rsp_median_ff;

`ifndef SYNTHESIS
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == dsm3_pkg::KIND_CLEARED)) |->
      ((rsp_entries_held == dsm3_pkg::COUNT_EMPTY) && (rsp_history_sum == 34'sd0)))
      else $error("cleared beat carries nonzero statistics");

   a_entry_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == dsm3_pkg::KIND_ENTRY)) |->
      (rsp_entries_held != dsm3_pkg::COUNT_EMPTY))
      else $error("entry beat reports an empty window");

   a_single_median: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == dsm3_pkg::KIND_ENTRY) &&
       (rsp_entries_held == dsm3_pkg::COUNT_ONE)) |->
      (rsp_history_median == rsp_entered_value))
      else $error("median of a single entry differs from the entry");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid)
      else $error("loaded response not presented");
`endif

endmodule
`default_nettype wire

// ===== dv/decimal_entry_sum_median3_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_entry_sum_median3_top_tb
// Checks the decimal entry block against its own running copy of the parser
// and the three-entry window. Each accepted character updates the copy and
// queues the beat it should produce. Each response beat is compared field by
// field with the oldest queued beat. Stimulus is a short directed string,
// then random entries, noise and broken numbers. Idling on both channels
// goes through three profiles.
// ----------------------------------------------------------------------------
module decimal_entry_sum_median3_top_tb;

   localparam int unsigned VALUE_BITS = 32;
   localparam int          IDLE_LIMIT = 4000;
   localparam int          PHASE_CHARS = 650;

   typedef struct packed {
      logic              kind;
      logic signed [31:0] value;
      logic [1:0]        held;
      logic signed [33:0] total;
      logic signed [31:0] median;
   } entry_result_type;

   class window_scoreboard;
      entry_result_type     expected_q[$];
      int                   errors;
      longint               recent[3];
      int                   held;
      dsm3_pkg::phase_type  phase;
      bit                   negative;
      longint unsigned      mag;

      function new();
         errors = 0;
         recent = '{0, 0, 0};
         held = 0;
         phase = dsm3_pkg::PH_SPACE;
         negative = 1'b0;
         mag = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_char(logic [7:0] c);
         longint unsigned  limit;
         longint           v, a, b, d, total, med, lo, hi, mid;
         entry_result_type r;
         bit               is_space, is_digit;
         limit = 64'd1 << (VALUE_BITS - 1);
         is_space = (c == dsm3_pkg::CHAR_SPACE) ||
                    (c >= dsm3_pkg::CHAR_TAB && c <= dsm3_pkg::CHAR_CR);
         is_digit = (c >= dsm3_pkg::CHAR_ZERO && c <= dsm3_pkg::CHAR_NINE);
         r = '0;
         if (c == dsm3_pkg::CHAR_LOWER_F || c == dsm3_pkg::CHAR_UPPER_F) begin
            recent = '{0, 0, 0};
            held = 0;
            r.kind = dsm3_pkg::KIND_CLEARED;
            expected_q.push_back(r);
         end else if (c == dsm3_pkg::CHAR_LOWER_E || c == dsm3_pkg::CHAR_UPPER_E) begin
            if (mag >= limit)
               v = negative ? -longint'(limit) : longint'(limit) - 1;
            else
               v = negative ? -longint'(mag) : longint'(mag);
            phase = dsm3_pkg::PH_SPACE;
            negative = 1'b0;
            mag = 0;
            if (held < 3) begin
               recent[held] = v;
               held++;
            end else begin
               recent[0] = recent[1];
               recent[1] = recent[2];
               recent[2] = v;
            end
            a = recent[0];
            b = recent[1];
            d = recent[2];
            if (held == 1) begin
               total = a;
               med = a;
            end else if (held == 2) begin
               total = a + b;
               med = total / 2;
            end else begin
               total = a + b + d;
               lo = (a < b) ? a : b;
               hi = (a > b) ? a : b;
               mid = (hi < d) ? hi : d;
               med = (lo > mid) ? lo : mid;
            end
            r.kind = dsm3_pkg::KIND_ENTRY;
            r.value = v[31:0];
            r.held = held[1:0];
            r.total = total[33:0];
            r.median = med[31:0];
            expected_q.push_back(r);
         end else if (phase != dsm3_pkg::PH_STOP) begin
            if (is_digit) begin
               mag = mag * 10 + (c - dsm3_pkg::CHAR_ZERO);
               if (mag > limit)
                  mag = limit;
               phase = dsm3_pkg::PH_DIGITS;
            end else if (phase == dsm3_pkg::PH_SPACE && is_space) begin
               phase = dsm3_pkg::PH_SPACE;
            end else if (phase == dsm3_pkg::PH_SPACE &&
                         (c == dsm3_pkg::CHAR_PLUS || c == dsm3_pkg::CHAR_MINUS)) begin
               negative = (c == dsm3_pkg::CHAR_MINUS);
               phase = dsm3_pkg::PH_SIGN;
            end else begin
               phase = dsm3_pkg::PH_STOP;
            end
         end
      endfunction

      function void report(string what, longint exp_v, longint got_v);
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
      endfunction

      function void check_result(entry_result_type got);
         entry_result_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, got kind %0d value %0d",
                     $time, got.kind, $signed(got.value));
            return;
         end
         want = expected_q.pop_front();
         if (got.kind !== want.kind)
            report("result_kind", want.kind, got.kind);
         if (got.value !== want.value)
            report("entered_value", $signed(want.value), $signed(got.value));
         if (got.held !== want.held)
            report("entries_held", want.held, got.held);
         if (got.total !== want.total)
            report("history_sum", $signed(want.total), $signed(got.total));
         if (got.median !== want.median)
            report("history_median", $signed(want.median), $signed(got.median));
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [7:0]        req_char_code = 8'd0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_result_kind;
   logic signed [31:0] rsp_entered_value;
   logic [1:0]        rsp_entries_held;
   logic signed [33:0] rsp_history_sum;
   logic signed [31:0] rsp_history_median;

   int                send_gap_pct = 0;
   int                rsp_stall_pct = 0;
   int                idle_cycles = 0;
   window_scoreboard  sb = new();

   logic [7:0] directed_chars [22] = '{
      dsm3_pkg::CHAR_UPPER_F, dsm3_pkg::CHAR_LOWER_E,
      dsm3_pkg::CHAR_TAB, dsm3_pkg::CHAR_MINUS, 8'h00, dsm3_pkg::CHAR_UPPER_E,
      dsm3_pkg::CHAR_NINE, dsm3_pkg::CHAR_NINE, dsm3_pkg::CHAR_NINE,
      dsm3_pkg::CHAR_NINE, dsm3_pkg::CHAR_NINE, dsm3_pkg::CHAR_NINE,
      dsm3_pkg::CHAR_NINE, dsm3_pkg::CHAR_NINE, dsm3_pkg::CHAR_NINE,
      dsm3_pkg::CHAR_NINE, dsm3_pkg::CHAR_LOWER_E,
      dsm3_pkg::CHAR_MINUS, dsm3_pkg::CHAR_ZERO + 8'd8, 8'hFF, dsm3_pkg::CHAR_LOWER_E,
      dsm3_pkg::CHAR_LOWER_F
   };

   decimal_entry_sum_median3_top #(
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_char_code      (req_char_code),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_entered_value  (rsp_entered_value),
      .rsp_entries_held   (rsp_entries_held),
      .rsp_history_sum    (rsp_history_sum),
      .rsp_history_median (rsp_history_median)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_char(req_char_code);
         if (rsp_valid && rsp_ready)
            sb.check_result({rsp_result_kind, rsp_entered_value, rsp_entries_held,
                             rsp_history_sum, rsp_history_median});
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[decimal_entry_sum_median3_top] ERROR");
         $finish;
      end
   end

   task automatic send_char(input logic [7:0] c);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= c;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   task automatic send_random(input int count);
      logic [7:0]      seq[$];
      logic [7:0]      digits[$];
      longint unsigned num;
      int              sent, r, k, nd, pos;
      sent = 0;
      while (sent < count) begin
         seq.delete();
         digits.delete();
         r = $urandom_range(0, 99);
         if (r < 6) begin
            seq.push_back($urandom_range(0, 1) ? dsm3_pkg::CHAR_LOWER_F
                                               : dsm3_pkg::CHAR_UPPER_F);
         end else if (r < 18) begin
            nd = $urandom_range(1, 4);
            repeat (nd) seq.push_back(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(0, 2)) begin
               k = $urandom_range(0, 5);
               seq.push_back((k == 5) ? dsm3_pkg::CHAR_SPACE : 8'(dsm3_pkg::CHAR_TAB + k));
            end
            k = $urandom_range(0, 2);
            if (k == 1)
               seq.push_back(dsm3_pkg::CHAR_PLUS);
            else if (k == 2)
               seq.push_back(dsm3_pkg::CHAR_MINUS);
            k = $urandom_range(0, 99);
            if (k < 10) begin
               case ($urandom_range(0, 3))
                  0: num = 64'd2147483647;
                  1: num = 64'd2147483648;
                  2: num = 64'd2147483649;
                  default: num = 64'd99999999999;
               endcase
               do begin
                  digits.push_front(8'(dsm3_pkg::CHAR_ZERO + num % 10));
                  num = num / 10;
               end while (num != 0);
               if ($urandom_range(0, 3) == 0)
                  repeat ($urandom_range(1, 3)) digits.push_front(dsm3_pkg::CHAR_ZERO);
            end else begin
               nd = (k < 22) ? $urandom_range(9, 12) : $urandom_range(0, 4);
               repeat (nd) digits.push_back(8'(dsm3_pkg::CHAR_ZERO + $urandom_range(0, 9)));
            end
            foreach (digits[i]) seq.push_back(digits[i]);
            if ($urandom_range(0, 9) == 0) begin
               pos = $urandom_range(0, seq.size());
               seq.insert(pos, 8'($urandom_range(0, 255)));
            end
            seq.push_back($urandom_range(0, 1) ? dsm3_pkg::CHAR_LOWER_E
                                               : dsm3_pkg::CHAR_UPPER_E);
         end
         foreach (seq[i]) send_char(seq[i]);
         sent += seq.size();
      end
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      send_gap_pct = 6;
      rsp_stall_pct = 68;
      foreach (directed_chars[i]) send_char(directed_chars[i]);
      send_random(PHASE_CHARS);

      send_gap_pct = 68;
      rsp_stall_pct = 6;
      send_random(PHASE_CHARS);

      send_gap_pct = 0;
      rsp_stall_pct = 0;
      send_random(PHASE_CHARS);

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (sb.errors == 0)
         $display("[decimal_entry_sum_median3_top] OK");
      else
         $display("[decimal_entry_sum_median3_top] ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/dsm3_pkg.sv
sv/dsm3_parser.sv
sv/dsm3_window.sv
sv/decimal_entry_sum_median3_top.sv
dv/decimal_entry_sum_median3_top_tb.sv
